// File: rtl/sfr_pkg.sv
// Package for the stream find-and-replace unit: sizes, payload and control types.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam int unsigned PatternMax    = 8;
  localparam int unsigned SubstituteMax = 8;
  localparam int unsigned LenW          = 4;
  localparam int unsigned IdxW          = 3;

  localparam logic [63:0]     PatternReset    = 64'h2424;
  localparam logic [LenW-1:0] PatternLenReset = 4'd2;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] RegPatternBytes    = 2'd0;
  localparam logic [1:0] RegPatternLength   = 2'd1;
  localparam logic [1:0] RegSubstituteBytes = 2'd2;
  localparam logic [1:0] RegSubstituteLen   = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       out_last;
  } sfr_out_t;

  // configuration as seen by the datapath, lengths already clamped
  typedef struct packed {
    logic [63:0]     pattern_bytes;
    logic [LenW-1:0] pattern_len;
    logic [63:0]     substitute_bytes;
    logic [LenW-1:0] substitute_len;
  } sfr_cfg_t;

  typedef struct packed {
    logic load;
    logic shift;
  } sfr_cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/stream_find_and_replace_unit.sv
// Top level of the stream find-and-replace unit: cell row, sequencer, output register.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   in       | sink      | in_valid_i / in_stall_o | in_data_i  (sfr_in_t)
//   out      | source    | out_valid_o/out_stall_i | out_data_o (sfr_out_t)
//   config   | sink      | APB psel/penable/pready | paddr, pwdata, prdata
//
// One request at a time: it is accepted and decided, then its results are emitted
// while the output register is free; a shift loop ends with a pass that emits nothing.
// The row of eight window cells shifts by one byte per cycle when the output is free.
// Reset clears the sequencer, the window count and the output valid; cell bytes are
// not reset. out_stall_i holds a valid output register and stalls the emitting states.
`timescale 1ns / 1ps
`default_nettype none

module stream_find_and_replace_unit
  import sfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire sfr_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output sfr_out_t         out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecide = 3'd1;
  localparam logic [2:0] StShift  = 3'd2;
  localparam logic [2:0] StSub    = 3'd3;
  localparam logic [2:0] StMark   = 3'd4;

  sfr_cfg_t cfg;

  logic [2:0]      state_q, state_d;
  logic [LenW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            last_q, last_d;
  logic            out_valid_q, out_valid_d;
  sfr_out_t        out_data_q, out_data_d;

  logic                 accept;
  logic                 out_free;
  logic                 emit;
  logic                 shift_en;
  logic [IdxW-1:0]      wr_idx;
  logic                 prefix_ok;
  logic                 shift_cond;
  logic [PatternMax-1:0] match;
  logic [7:0]           cell_byte [PatternMax];
  sfr_cell_ctrl_t       cell_ctrl [PatternMax];

  sfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // a full window overwrites its newest byte
  assign wr_idx = (count_q >= LenW'(PatternMax)) ? IdxW'(PatternMax - 1) : count_q[IdxW-1:0];

  for (genvar i = 0; i < PatternMax; i++) begin : g_cell
    assign cell_ctrl[i].load  = accept && (wr_idx == IdxW'(i));
    assign cell_ctrl[i].shift = shift_en;

    sfr_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .load_byte_i (in_data_i.in_byte),
      .nbr_byte_i  (cell_byte[(i == PatternMax - 1) ? i : i + 1]),
      .pat_byte_i  (cfg.pattern_bytes[8*i +: 8]),
      .byte_o      (cell_byte[i]),
      .match_o     (match[i])
    );
  end

  // held bytes all agree with the pattern head
  always_comb begin
    prefix_ok = 1'b1;
    for (int i = 0; i < PatternMax; i++) begin
      if ((LenW'(i) < count_q) && !match[i]) begin
        prefix_ok = 1'b0;
      end
    end
  end

  assign shift_cond = (count_q != '0) &&
                      (last_q || (count_q >= cfg.pattern_len) || !prefix_ok);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    last_d     = last_q;
    emit       = 1'b0;
    shift_en   = 1'b0;
    out_data_d = out_data_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          count_d = (count_q >= LenW'(PatternMax)) ? LenW'(PatternMax) : count_q + LenW'(1);
          last_d  = in_data_i.in_last;
          state_d = StDecide;
        end
      end
      StDecide: begin
        idx_d = '0;
        if ((count_q == cfg.pattern_len) && prefix_ok) begin
          count_d = '0;
          if (cfg.substitute_len != '0) begin
            state_d = StSub;
          end else if (last_q) begin
            state_d = StMark;
          end else begin
            state_d = StIdle;
          end
        end else begin
          state_d = StShift;
        end
      end
      StShift: begin
        if (!shift_cond) begin
          state_d = StIdle;
        end else if (out_free) begin
          emit                      = 1'b1;
          shift_en                  = 1'b1;
          out_data_d.out_byte       = cell_byte[0];
          out_data_d.out_byte_valid = 1'b1;
          out_data_d.out_last       = last_q && (count_q == LenW'(1));
          count_d                   = count_q - LenW'(1);
        end
      end
      StSub: begin
        if (out_free) begin
          emit                      = 1'b1;
          out_data_d.out_byte       = cfg.substitute_bytes[{idx_q, 3'b000} +: 8];
          out_data_d.out_byte_valid = 1'b1;
          out_data_d.out_last       = 1'b0;
          if ({1'b0, idx_q} == cfg.substitute_len - LenW'(1)) begin
            out_data_d.out_last = last_q;
            state_d             = StIdle;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      StMark: begin
        if (out_free) begin
          emit                      = 1'b1;
          out_data_d.out_byte       = '0;
          out_data_d.out_byte_valid = 1'b0;
          out_data_d.out_last       = 1'b1;
          state_d                   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = emit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/sfr_cell.sv
// One cell of the match window: holds a byte, compares it to its pattern byte.
`timescale 1ns / 1ps
`default_nettype none

module sfr_cell
  import sfr_pkg::*;
(
  input  wire logic           clk_i,
  input  wire sfr_cell_ctrl_t ctrl_i,
  input  wire logic [7:0]     load_byte_i,
  input  wire logic [7:0]     nbr_byte_i,
  input  wire logic [7:0]     pat_byte_i,
  output logic [7:0]          byte_o,
  output logic                match_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.load) begin
      byte_d = load_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = nbr_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o  = byte_q;
  assign match_o = (byte_q == pat_byte_i);

endmodule

`default_nettype wire

// File: rtl/sfr_regs.sv
// APB configuration registers of the stream find-and-replace unit.
`timescale 1ns / 1ps
`default_nettype none

module sfr_regs
  import sfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output sfr_cfg_t         cfg_o
);

  logic [63:0]     pat_q, pat_d;
  logic [LenW-1:0] plen_q, plen_d;
  logic [63:0]     sub_q, sub_d;
  logic [LenW-1:0] slen_q, slen_d;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];

  always_comb begin
    pat_d  = pat_q;
    plen_d = plen_q;
    sub_d  = sub_q;
    slen_d = slen_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegPatternBytes:    pat_d  = pwdata;
        RegPatternLength:   plen_d = pwdata[LenW-1:0];
        RegSubstituteBytes: sub_d  = pwdata;
        RegSubstituteLen:   slen_d = pwdata[LenW-1:0];
        default:            pat_d  = pat_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= PatternReset;
      plen_q <= PatternLenReset;
      sub_q  <= '0;
      slen_q <= '0;
    end else begin
      pat_q  <= pat_d;
      plen_q <= plen_d;
      sub_q  <= sub_d;
      slen_q <= slen_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPatternBytes:    prdata = pat_q;
      RegPatternLength:   prdata = {{(64-LenW){1'b0}}, plen_q};
      RegSubstituteBytes: prdata = sub_q;
      RegSubstituteLen:   prdata = {{(64-LenW){1'b0}}, slen_q};
      default:            prdata = '0;
    endcase
  end

  // clamp lengths: empty pattern counts as one byte
  always_comb begin
    cfg_o.pattern_bytes    = pat_q;
    cfg_o.substitute_bytes = sub_q;
    if (plen_q == '0) begin
      cfg_o.pattern_len = LenW'(1);
    end else if (plen_q > LenW'(PatternMax)) begin
      cfg_o.pattern_len = LenW'(PatternMax);
    end else begin
      cfg_o.pattern_len = plen_q;
    end
    if (slen_q > LenW'(SubstituteMax)) begin
      cfg_o.substitute_len = LenW'(SubstituteMax);
    end else begin
      cfg_o.substitute_len = slen_q;
    end
  end

endmodule

`default_nettype wire
